FILE: src/raycast_column_ray_setup_defines.svh
// ----------------------------------------------------------------------------
// Ray setup assertion macros
// Shared assertion forms for the column ray setup checker.
// ----------------------------------------------------------------------------
`ifndef RAYCAST_COLUMN_RAY_SETUP_DEFINES_SVH
`define RAYCAST_COLUMN_RAY_SETUP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rcs_pkg.sv
// ----------------------------------------------------------------------------
// Ray setup package
// Formats, constants, register codes and helpers of the column ray setup.
// ----------------------------------------------------------------------------
package rcs_pkg;

    // Geometry of the screen and the map.
    localparam int SCREEN_WIDTH = 1024;
    localparam int MAP_CELLS    = 64;

    // Field widths.
    localparam int COL_W   = 10;
    localparam int POS_W   = 22;
    localparam int VEC_W   = 19;
    localparam int CFG_W   = 22;
    localparam int IDX_W   = 3;
    localparam int RAY_W   = 20;
    localparam int CELL_W  = 6;
    localparam int DIST_W  = 24;
    localparam int FRAC_W  = 16;

    // Internal widths.
    localparam int CAM_W   = 28;
    localparam int PROD_W  = 47;
    localparam int ABS_W   = 20;
    localparam int SQ_W    = 39;
    localparam int SUM_W   = 40;
    localparam int QUO_W   = 48;
    localparam int ROOT_W  = 24;
    localparam int SROW_W  = 26;

    // Camera coordinate by reciprocal: q0 = (column * RECIP) >> RECIP_SHIFT.
    localparam int RECIP_SHIFT = 10;
    localparam int RECIP       = (1 << (FRAC_W + 1 + RECIP_SHIFT)) / SCREEN_WIDTH;
    localparam int RECIP_W     = 27;
    localparam int CAMQ_W      = 26;
    localparam int ONE_Q16     = 1 << FRAC_W;

    // Pipeline depths.
    localparam int FRONT_LAT = 4;
    localparam int DELTA_LAT = 2 + QUO_W + ROOT_W;
    localparam int TOTAL_LAT = FRONT_LAT + DELTA_LAT + 2;

    localparam logic [DIST_W-1:0]       DIST_MAX = {DIST_W{1'b1}};
    localparam logic signed [RAY_W-1:0] RAY_MAX  = {1'b0, {(RAY_W-1){1'b1}}};
    localparam logic signed [RAY_W-1:0] RAY_MIN  = {1'b1, {(RAY_W-1){1'b0}}};

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_POS_X   = 3'd0,
        REG_POS_Y   = 3'd1,
        REG_DIR_X   = 3'd2,
        REG_DIR_Y   = 3'd3,
        REG_PLANE_X = 3'd4,
        REG_PLANE_Y = 3'd5
    } t_cfg_reg;

    // Clamp a wide signed sum to the ray range.
    function automatic logic signed [RAY_W-1:0] sat_ray(input logic signed [31:0] v);
        logic signed [RAY_W-1:0] res;
        if (v > 32'(RAY_MAX)) begin
            res = RAY_MAX;
        end else if (v < 32'(RAY_MIN)) begin
            res = RAY_MIN;
        end else begin
            res = RAY_W'(v);
        end
        return res;
    endfunction

endpackage

FILE: src/raycast_column_ray_setup.sv
// Throughput: one column per cycle while no result is held; the depth is set
// by the 48 divide stages and 24 square root stages of each delta distance unit.
// The whole pipeline advances together; it holds while a result waits.
// Reset (synchronous, active low) clears all valid bits and loads the
// register defaults; no transfer is accepted while reset is asserted.
// ----------------------------------------------------------------------------
// Column ray setup
// Computes ray direction, start cell, step signs, delta and side distances
// for one screen column per transfer of a grid raycaster.
// ----------------------------------------------------------------------------
module raycast_column_ray_setup (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rcs_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [rcs_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [rcs_pkg::COL_W-1:0]         i_column,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [rcs_pkg::RAY_W-1:0]  o_ray_x,
    output logic signed [rcs_pkg::RAY_W-1:0]  o_ray_y,
    output logic [rcs_pkg::CELL_W-1:0]        o_cell_x,
    output logic [rcs_pkg::CELL_W-1:0]        o_cell_y,
    output logic                              o_step_x_negative,
    output logic                              o_step_y_negative,
    output logic [rcs_pkg::DIST_W-1:0]        o_delta_x,
    output logic [rcs_pkg::DIST_W-1:0]        o_delta_y,
    output logic [rcs_pkg::DIST_W-1:0]        o_side_x,
    output logic [rcs_pkg::DIST_W-1:0]        o_side_y
);
    import rcs_pkg::*;

    localparam logic [CELL_W-1:0] CELL_LIM =
        CELL_W'((MAP_CELLS - 1 > 63) ? 63 : MAP_CELLS - 1);
    localparam int SPROD_W = POS_W + DIST_W;

    logic [POS_W-1:0]        r_pos_x;
    logic [POS_W-1:0]        r_pos_y;
    logic signed [VEC_W-1:0] r_dir_x;
    logic signed [VEC_W-1:0] r_dir_y;
    logic signed [VEC_W-1:0] r_plane_x;
    logic signed [VEC_W-1:0] r_plane_y;

    logic                    r_vld [0:TOTAL_LAT-1];
    logic                    en;

    logic signed [RAY_W-1:0] ray_x;
    logic signed [RAY_W-1:0] ray_y;
    logic [DIST_W-1:0]       dlt_x;
    logic [DIST_W-1:0]       dlt_y;
    logic [2*RAY_W-1:0]      ray_dly;

    logic [CELL_W-1:0]       cell_x;
    logic [CELL_W-1:0]       cell_y;
    logic [POS_W-1:0]        frac_x;
    logic [POS_W-1:0]        frac_y;

    logic [SPROD_W-1:0]      r_sp_x;
    logic [SPROD_W-1:0]      r_sp_y;
    logic [CELL_W-1:0]       r_t_cell_x;
    logic [CELL_W-1:0]       r_t_cell_y;
    logic [2*RAY_W-1:0]      r_t_ray;
    logic [DIST_W-1:0]       r_t_dlt_x;
    logic [DIST_W-1:0]       r_t_dlt_y;

    logic [2*RAY_W-1:0]      r_o_ray;
    logic [CELL_W-1:0]       r_o_cell_x;
    logic [CELL_W-1:0]       r_o_cell_y;
    logic [DIST_W-1:0]       r_o_dlt_x;
    logic [DIST_W-1:0]       r_o_dlt_y;
    logic [DIST_W-1:0]       r_o_side_x;
    logic [DIST_W-1:0]       r_o_side_y;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_dir_x   <= VEC_W'(65536);
            r_dir_y   <= '0;
            r_plane_x <= '0;
            r_plane_y <= VEC_W'(43254);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_POS_X:   r_pos_x   <= i_cfg_data[POS_W-1:0];
                REG_POS_Y:   r_pos_y   <= i_cfg_data[POS_W-1:0];
                REG_DIR_X:   r_dir_x   <= signed'(i_cfg_data[VEC_W-1:0]);
                REG_DIR_Y:   r_dir_y   <= signed'(i_cfg_data[VEC_W-1:0]);
                REG_PLANE_X: r_plane_x <= signed'(i_cfg_data[VEC_W-1:0]);
                REG_PLANE_Y: r_plane_y <= signed'(i_cfg_data[VEC_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    // The pipeline advances unless a finished result is held by the receiver.
    assign en          = !(r_vld[TOTAL_LAT-1] && i_out_stall);
    assign o_in_stall  = !en || !i_rst_n;
    assign o_out_valid = r_vld[TOTAL_LAT-1];

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TOTAL_LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int i = 1; i < TOTAL_LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    rcs_front u_front (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_column      (i_column),
        .i_view_dir_x  (r_dir_x),
        .i_view_dir_y  (r_dir_y),
        .i_cam_plane_x (r_plane_x),
        .i_cam_plane_y (r_plane_y),
        .o_ray_x       (ray_x),
        .o_ray_y       (ray_y)
    );

    rcs_delta u_delta_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_own   (ray_x),
        .i_other (ray_y),
        .o_delta (dlt_x)
    );

    rcs_delta u_delta_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_own   (ray_y),
        .i_other (ray_x),
        .o_delta (dlt_y)
    );

    rcs_delay #(
        .WIDTH (2 * RAY_W),
        .DEPTH (DELTA_LAT)
    ) u_ray_dly (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({ray_x, ray_y}),
        .o_q   (ray_dly)
    );

    // Start cell and fraction to the first grid line on each axis.
    function automatic logic [CELL_W-1:0] cell_of(input logic [POS_W-1:0] pos);
        logic [CELL_W-1:0] raw;
        raw = pos[POS_W-1:FRAC_W];
        return (raw > CELL_LIM) ? CELL_LIM : raw;
    endfunction

    function automatic logic [POS_W-1:0] frac_of(input logic [POS_W-1:0]  pos,
                                                 input logic [CELL_W-1:0] cell_idx,
                                                 input logic              neg);
        logic [POS_W:0]   edge_pos;
        logic [POS_W-1:0] res;
        edge_pos = (POS_W+1)'(cell_idx + 1'b1 == '0 ? {1'b1, {CELL_W{1'b0}}} :
                   {1'b0, cell_idx + CELL_W'(1)}) << FRAC_W;
        if (neg) begin
            res = pos - (POS_W'(cell_idx) << FRAC_W);
        end else if (edge_pos > (POS_W+1)'(pos)) begin
            res = POS_W'(edge_pos - (POS_W+1)'(pos));
        end else begin
            res = '0;
        end
        return res;
    endfunction

    assign cell_x = cell_of(r_pos_x);
    assign cell_y = cell_of(r_pos_y);
    assign frac_x = frac_of(r_pos_x, cell_x, ray_dly[2*RAY_W-1]);
    assign frac_y = frac_of(r_pos_y, cell_y, ray_dly[RAY_W-1]);

    // Side distance product stage.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sp_x     <= SPROD_W'(frac_x) * SPROD_W'(dlt_x);
            r_sp_y     <= SPROD_W'(frac_y) * SPROD_W'(dlt_y);
            r_t_cell_x <= cell_x;
            r_t_cell_y <= cell_y;
            r_t_ray    <= ray_dly;
            r_t_dlt_x  <= dlt_x;
            r_t_dlt_y  <= dlt_y;
        end
    end

    // Output register stage with side distance saturation.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_ray    <= r_t_ray;
            r_o_cell_x <= r_t_cell_x;
            r_o_cell_y <= r_t_cell_y;
            r_o_dlt_x  <= r_t_dlt_x;
            r_o_dlt_y  <= r_t_dlt_y;
            r_o_side_x <= ((r_sp_x >> FRAC_W) > SPROD_W'(DIST_MAX)) ? DIST_MAX :
                          DIST_W'(r_sp_x >> FRAC_W);
            r_o_side_y <= ((r_sp_y >> FRAC_W) > SPROD_W'(DIST_MAX)) ? DIST_MAX :
                          DIST_W'(r_sp_y >> FRAC_W);
        end
    end

    assign o_ray_x           = signed'(r_o_ray[2*RAY_W-1:RAY_W]);
    assign o_ray_y           = signed'(r_o_ray[RAY_W-1:0]);
    assign o_cell_x          = r_o_cell_x;
    assign o_cell_y          = r_o_cell_y;
    assign o_step_x_negative = r_o_ray[2*RAY_W-1];
    assign o_step_y_negative = r_o_ray[RAY_W-1];
    assign o_delta_x         = r_o_dlt_x;
    assign o_delta_y         = r_o_dlt_y;
    assign o_side_x          = r_o_side_x;
    assign o_side_y          = r_o_side_y;

endmodule

FILE: src/rcs_delay.sv
// ----------------------------------------------------------------------------
// Ray setup delay line
// Fixed-length register line that keeps side data aligned with a pipeline.
// ----------------------------------------------------------------------------
module rcs_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_line [0:DEPTH-1];

    // Shift one place per advance of the pipeline.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_line[i] <= r_line[i-1];
            end
        end
    end

    assign o_q = r_line[DEPTH-1];

endmodule

FILE: src/rcs_front.sv
// ----------------------------------------------------------------------------
// Ray setup front end
// Camera coordinate of a column and the ray direction, in four stages.
// ----------------------------------------------------------------------------
module rcs_front (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [rcs_pkg::COL_W-1:0]           i_column,
    input  logic signed [rcs_pkg::VEC_W-1:0]    i_view_dir_x,
    input  logic signed [rcs_pkg::VEC_W-1:0]    i_view_dir_y,
    input  logic signed [rcs_pkg::VEC_W-1:0]    i_cam_plane_x,
    input  logic signed [rcs_pkg::VEC_W-1:0]    i_cam_plane_y,
    output logic signed [rcs_pkg::RAY_W-1:0]    o_ray_x,
    output logic signed [rcs_pkg::RAY_W-1:0]    o_ray_y
);
    import rcs_pkg::*;

    logic [COL_W-1:0]         r_col;
    logic [CAMQ_W-1:0]        r_q0;
    logic signed [CAM_W-1:0]  r_cam;
    logic signed [PROD_W-1:0] r_px;
    logic signed [PROD_W-1:0] r_py;
    logic signed [RAY_W-1:0]  r_rx;
    logic signed [RAY_W-1:0]  r_ry;

    logic [36:0]              q0_prod;
    logic [39:0]              q_num;
    logic [39:0]              q_back;
    logic [39:0]              q_rem;
    logic [CAMQ_W-1:0]        q_fix;
    logic [CAM_W-1:0]         cam_u;
    logic signed [31:0]       sum_x;
    logic signed [31:0]       sum_y;

    // Estimate of 2*column*65536/SCREEN_WIDTH, low by at most one.
    assign q0_prod = 37'(i_column) * 37'(RECIP);

    // Correct the estimate with one back-multiplication and compare.
    always_comb begin
        q_num  = 40'(r_col) << (FRAC_W + 1);
        q_back = 40'(r_q0) * 40'(SCREEN_WIDTH);
        q_rem  = q_num - q_back;
        q_fix  = (q_rem >= 40'(SCREEN_WIDTH)) ? r_q0 + CAMQ_W'(1) : r_q0;
        cam_u  = CAM_W'(q_fix) - CAM_W'(ONE_Q16);
    end

    // Ray component is direction plus the floored plane product.
    assign sum_x = 32'(i_view_dir_x) + 32'(r_px >>> FRAC_W);
    assign sum_y = 32'(i_view_dir_y) + 32'(r_py >>> FRAC_W);

    // Four pipeline registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_col <= i_column;
            r_q0  <= CAMQ_W'(q0_prod >> RECIP_SHIFT);
            r_cam <= signed'(cam_u);
            r_px  <= PROD_W'(i_cam_plane_x) * PROD_W'(r_cam);
            r_py  <= PROD_W'(i_cam_plane_y) * PROD_W'(r_cam);
            r_rx  <= sat_ray(sum_x);
            r_ry  <= sat_ray(sum_y);
        end
    end

    assign o_ray_x = r_rx;
    assign o_ray_y = r_ry;

endmodule

FILE: src/rcs_delta.sv
// ----------------------------------------------------------------------------
// Ray setup delta distance
// Pipelined floor(sqrt((own^2+other^2) * 2^32 / own^2)): squares, one
// restoring divide stage per quotient bit, one square root stage per bit.
// ----------------------------------------------------------------------------
module rcs_delta (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [rcs_pkg::RAY_W-1:0]  i_own,
    input  logic signed [rcs_pkg::RAY_W-1:0]  i_other,
    output logic [rcs_pkg::DIST_W-1:0]        o_delta
);
    import rcs_pkg::*;

    logic [ABS_W-1:0]  own_abs;
    logic [ABS_W-1:0]  oth_abs;
    logic [SQ_W-1:0]   r_a2;
    logic [SQ_W-1:0]   r_b2;
    logic              r_zero;
    logic [SUM_W-1:0]  sum;
    logic              ovf;

    logic [SQ_W-1:0]   r_div_rem [0:QUO_W-1];
    logic [FRAC_W-1:0] r_div_num [0:QUO_W-1];
    logic [SQ_W-1:0]   r_div_d   [0:QUO_W-1];
    logic [QUO_W-1:0]  r_div_q   [0:QUO_W];
    logic              r_div_sat [0:QUO_W];

    logic [SROW_W-1:0] r_sq_rem  [1:ROOT_W-1];
    logic [QUO_W-1:0]  r_sq_bits [1:ROOT_W-1];
    logic [ROOT_W-1:0] r_sq_root [1:ROOT_W];
    logic              r_sq_sat  [1:ROOT_W];

    // Magnitudes and their squares.
    assign own_abs = i_own[RAY_W-1]   ? ABS_W'(-i_own)   : ABS_W'(i_own);
    assign oth_abs = i_other[RAY_W-1] ? ABS_W'(-i_other) : ABS_W'(i_other);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a2   <= SQ_W'(own_abs) * SQ_W'(own_abs);
            r_b2   <= SQ_W'(oth_abs) * SQ_W'(oth_abs);
            r_zero <= (i_own == '0);
        end
    end

    // Sum of squares; the result saturates when the integer quotient reaches 2^16.
    assign sum = SUM_W'(r_a2) + SUM_W'(r_b2);
    assign ovf = r_zero || (55'(sum) >= (55'(r_a2) << FRAC_W));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div_rem[0] <= SQ_W'(sum >> FRAC_W);
            r_div_num[0] <= sum[FRAC_W-1:0];
            r_div_d[0]   <= r_a2;
            r_div_q[0]   <= '0;
            r_div_sat[0] <= ovf;
        end
    end

    // Restoring divide, one quotient bit per stage.
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        logic [SQ_W:0]    trial;
        logic             take;
        logic [SQ_W:0]    diff;

        assign trial = {r_div_rem[k], r_div_num[k][FRAC_W-1]};
        assign take  = trial >= {1'b0, r_div_d[k]};
        assign diff  = trial - {1'b0, r_div_d[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_div_q[k+1]   <= {r_div_q[k][QUO_W-2:0], take};
                r_div_sat[k+1] <= r_div_sat[k];
            end
        end

        if (k < QUO_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_div_rem[k+1] <= take ? SQ_W'(diff) : SQ_W'(trial);
                    r_div_num[k+1] <= r_div_num[k] << 1;
                    r_div_d[k+1]   <= r_div_d[k];
                end
            end
        end
    end

    // Digit-by-digit square root, one root bit per stage.
    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        logic [SROW_W-1:0] rem_in;
        logic [QUO_W-1:0]  bits_in;
        logic [ROOT_W-1:0] root_in;
        logic              sat_in;
        logic [SROW_W+1:0] acc;
        logic [SROW_W+1:0] test;
        logic              take;

        if (j == 0) begin : g_first
            assign rem_in  = '0;
            assign bits_in = r_div_q[QUO_W];
            assign root_in = '0;
            assign sat_in  = r_div_sat[QUO_W];
        end else begin : g_next
            assign rem_in  = r_sq_rem[j];
            assign bits_in = r_sq_bits[j];
            assign root_in = r_sq_root[j];
            assign sat_in  = r_sq_sat[j];
        end

        assign acc  = {rem_in, bits_in[QUO_W-1:QUO_W-2]};
        assign test = (SROW_W+2)'({root_in, 2'b01});
        assign take = acc >= test;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_root[j+1] <= {root_in[ROOT_W-2:0], take};
                r_sq_sat[j+1]  <= sat_in;
            end
        end

        if (j < ROOT_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sq_rem[j+1]  <= take ? SROW_W'(acc - test) : SROW_W'(acc);
                    r_sq_bits[j+1] <= bits_in << 2;
                end
            end
        end
    end

    assign o_delta = r_sq_sat[ROOT_W] ? DIST_MAX : r_sq_root[ROOT_W];

endmodule

FILE: src/rcs_checker.sv
// ----------------------------------------------------------------------------
// Ray setup checker
// Port-level assertions for the column ray setup, bound to the top level.
// ----------------------------------------------------------------------------
`include "raycast_column_ray_setup_defines.svh"

module rcs_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_in_stall,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [rcs_pkg::RAY_W-1:0]  o_ray_x,
    input  logic signed [rcs_pkg::RAY_W-1:0]  o_ray_y,
    input  logic                              o_step_x_negative,
    input  logic [rcs_pkg::DIST_W-1:0]        o_delta_x,
    input  logic [rcs_pkg::DIST_W-1:0]        o_delta_y
);
    import rcs_pkg::*;

    // Out of reset, the input side only stalls behind a result the receiver is holding.
    `RCS_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled without a held result")

    // A held result stays valid and keeps its x delta and y ray.
    `RCS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_delta_x) && $stable(o_ray_y), "held result changed")

    // A zero x ray component gives the saturated x delta.
    `RCS_ASSERT_NOW(a_zero_delta, i_clk, i_rst_n, o_out_valid && o_ray_x == '0, o_delta_x == DIST_MAX, "zero ray x without saturated delta")

    // Step sign follows the ray sign, and a zero y ray saturates its delta.
    `RCS_ASSERT_NOW(a_step_sign, i_clk, i_rst_n, o_out_valid, (o_step_x_negative == o_ray_x[RAY_W-1]) && (o_ray_y != '0 || o_delta_y == DIST_MAX), "step sign or y delta mismatch")

endmodule

bind raycast_column_ray_setup rcs_checker u_rcs_checker (.*);

FILE: test/tb_raycast_column_ray_setup.sv
// ----------------------------------------------------------------------------
// Column ray setup testbench
// Streams screen columns through the ray setup block under several camera
// settings with random idle and stall patterns. Each result is checked field
// by field against a local fixed-point model of the ray setup arithmetic.
// ----------------------------------------------------------------------------
module tb_raycast_column_ray_setup;
    import rcs_pkg::*;

    localparam int  CYCLE_LIMIT = 600000;
    localparam int  DRAIN_WAIT  = 100;
    localparam int  LONG_HOLD   = 400;
    localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(REG_PLANE_Y) + IDX_W'(1);
    localparam longint DMAX = 64'hFFFFFF;

    typedef struct packed {
        logic signed [RAY_W-1:0] ray_x;
        logic signed [RAY_W-1:0] ray_y;
        logic [CELL_W-1:0]       cell_x;
        logic [CELL_W-1:0]       cell_y;
        logic                    neg_x;
        logic                    neg_y;
        logic [DIST_W-1:0]       delta_x;
        logic [DIST_W-1:0]       delta_y;
        logic [DIST_W-1:0]       side_x;
        logic [DIST_W-1:0]       side_y;
    } t_ray_setup;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [IDX_W-1:0]         i_cfg_index;
    logic [CFG_W-1:0]         i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [COL_W-1:0]         i_column;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [RAY_W-1:0]  o_ray_x;
    logic signed [RAY_W-1:0]  o_ray_y;
    logic [CELL_W-1:0]        o_cell_x;
    logic [CELL_W-1:0]        o_cell_y;
    logic                     o_step_x_negative;
    logic                     o_step_y_negative;
    logic [DIST_W-1:0]        o_delta_x;
    logic [DIST_W-1:0]        o_delta_y;
    logic [DIST_W-1:0]        o_side_x;
    logic [DIST_W-1:0]        o_side_y;

    // Camera registers as the block should hold them.
    logic [POS_W-1:0]         cam_pos_x, cam_pos_y;
    logic signed [VEC_W-1:0]  cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y;

    logic [COL_W-1:0] column_queue[$];
    t_ray_setup       setup_expected[$];
    int               send_idle_pct, recv_stall_pct;
    int               mismatches, cycle_count, hold_left;
    logic             column_taken, hold_request, hold_done;

    raycast_column_ray_setup uut (.*);

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Integer square root, bit by bit.
    function automatic longint unsigned root_of(input longint unsigned v);
        longint unsigned res, bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v -= res + bit_w;
                res = (res >> 1) + bit_w;
            end else begin
                res >>= 1;
            end
            bit_w >>= 2;
        end
        return res;
    endfunction

    // Distance per cell crossing along one axis, saturated.
    function automatic longint unsigned cross_dist(input longint own, input longint other);
        longint unsigned a, b, r2, s, q, rem;
        a = (own < 0) ? -own : own;
        b = (other < 0) ? -other : other;
        if (a == 0) return DMAX;
        r2 = a * a;
        s = r2 + b * b;
        q = s / r2;
        if (q >= (64'd1 << 16)) return DMAX;
        // Quotient with 32 more fraction bits, floored, by long division.
        rem = s % r2;
        for (int i = 0; i < 32; i++) begin
            rem <<= 1;
            q <<= 1;
            if (rem >= r2) begin
                rem -= r2;
                q |= 64'd1;
            end
        end
        q = root_of(q);
        return (q > DMAX) ? DMAX : q;
    endfunction

    // Ray component with floored plane term, clamped to the ray range.
    function automatic longint ray_comp(input longint dir, input longint plane,
                                        input longint camx);
        longint r;
        r = dir + ((plane * camx) >>> 16);
        if (r > longint'(RAY_MAX)) r = RAY_MAX;
        if (r < longint'(RAY_MIN)) r = RAY_MIN;
        return r;
    endfunction

    // Start cell, step sign and first grid line distance for one axis.
    function automatic void axis_setup(input longint unsigned pos, input longint ray,
                                       input longint unsigned dist_in,
                                       output logic [CELL_W-1:0] cell_o,
                                       output logic neg,
                                       output logic [DIST_W-1:0] side);
        longint unsigned c, frac, d, line_pos;
        c = pos >> 16;
        if (c > MAP_CELLS - 1) c = MAP_CELLS - 1;
        neg = (ray < 0);
        if (neg) begin
            frac = pos - (c << 16);
        end else begin
            line_pos = (c + 1) << 16;
            frac = (line_pos > pos) ? line_pos - pos : 0;
        end
        d = (frac * dist_in) >> 16;
        side = DIST_W'((d > DMAX) ? DMAX : d);
        cell_o = c[CELL_W-1:0];
    endfunction

    // Full setup for one column under the current camera registers.
    function automatic t_ray_setup column_setup(input logic [COL_W-1:0] col);
        t_ray_setup r;
        longint camx, rx, ry;
        longint unsigned dx, dy;
        camx = longint'((64'd2 * col * ONE_Q16) / SCREEN_WIDTH) - ONE_Q16;
        rx = ray_comp(cam_dir_x, cam_plane_x, camx);
        ry = ray_comp(cam_dir_y, cam_plane_y, camx);
        dx = cross_dist(rx, ry);
        dy = cross_dist(ry, rx);
        r.ray_x = rx[RAY_W-1:0];
        r.ray_y = ry[RAY_W-1:0];
        r.delta_x = dx[DIST_W-1:0];
        r.delta_y = dy[DIST_W-1:0];
        axis_setup(cam_pos_x, rx, dx, r.cell_x, r.neg_x, r.side_x);
        axis_setup(cam_pos_y, ry, dy, r.cell_y, r.neg_y, r.side_y);
        return r;
    endfunction

    // Input side: record transfers and queue their expected setups.
    always @(posedge i_clk) begin
        column_taken <= i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            setup_expected.push_back(column_setup(i_column));
        end
    end

    // Column driver: a new column only after the previous transfer.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || column_taken) begin
            if (column_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_column   <= column_queue.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus one long hold on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left   <= 0;
            hold_done   <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_left   <= LONG_HOLD;
            hold_done   <= 1'b1;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_ray_setup got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_ray_x, o_ray_y, o_cell_x, o_cell_y, o_step_x_negative,
                    o_step_y_negative, o_delta_x, o_delta_y, o_side_x, o_side_y};
            if (setup_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result transfer: %p", got);
            end else begin
                want = setup_expected.pop_front();
                if (got.ray_x !== want.ray_x || got.ray_y !== want.ray_y ||
                    got.cell_x !== want.cell_x || got.cell_y !== want.cell_y ||
                    got.neg_x !== want.neg_x || got.neg_y !== want.neg_y ||
                    got.delta_x !== want.delta_x || got.delta_y !== want.delta_y ||
                    got.side_x !== want.side_x || got.side_y !== want.side_y) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Setup mismatch: expected %p", want);
                        $display("                actual   %p", got);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Wait until the pipeline has drained.
    task automatic wait_drained();
        while (column_queue.size() > 0 || i_in_valid || setup_expected.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // Register write while idle; the local copy follows it.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(value);
        case (idx)
            REG_POS_X:   cam_pos_x   = POS_W'(value);
            REG_POS_Y:   cam_pos_y   = POS_W'(value);
            REG_DIR_X:   cam_dir_x   = VEC_W'(value);
            REG_DIR_Y:   cam_dir_y   = VEC_W'(value);
            REG_PLANE_X: cam_plane_x = VEC_W'(value);
            REG_PLANE_Y: cam_plane_y = VEC_W'(value);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_camera(input int px, input int py, input int dx, input int dy,
                                input int plx, input int ply);
        wait_drained();
        write_reg(REG_POS_X, px);
        write_reg(REG_POS_Y, py);
        write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);
        write_reg(REG_PLANE_X, plx);
        write_reg(REG_PLANE_Y, ply);
    endtask

    function automatic int rand_vec();
        return int'($urandom_range(262144)) - 131072;
    endfunction

    // Random camera: positions inside the map, vectors from -131072 to 131072,
    // and now and then an axis-aligned ray.
    task automatic random_camera();
        int dx, dy, plx, ply;
        dx = rand_vec(); dy = rand_vec(); plx = rand_vec(); ply = rand_vec();
        if ($urandom_range(3) == 0) begin
            dy = 0;
            ply = 0;
        end
        write_camera($urandom_range(4194303), $urandom_range(4194303), dx, dy, plx, ply);
    endtask

    task automatic queue_random_columns(input int n);
        repeat (n) column_queue.push_back(COL_W'($urandom));
    endtask

    // Directed column set: edges, center, single bits and alternating bits.
    task automatic queue_edge_columns();
        column_queue.push_back('0);
        column_queue.push_back(COL_W'(1));
        column_queue.push_back(COL_W'(SCREEN_WIDTH / 2 - 1));
        column_queue.push_back(COL_W'(SCREEN_WIDTH / 2));
        column_queue.push_back('1);
        column_queue.push_back(COL_W'(341));
        column_queue.push_back(COL_W'(682));
    endtask

    // Main sequence.
    initial begin
        int phase;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_column = '0;
        i_out_stall = 1'b0;
        hold_request = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        send_idle_pct = 17;
        recv_stall_pct = 52;
        // Register defaults after reset.
        cam_pos_x = '0;
        cam_pos_y = '0;
        cam_dir_x = VEC_W'(65536);
        cam_dir_y = '0;
        cam_plane_x = '0;
        cam_plane_y = VEC_W'(43254);
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults straight after reset.
        queue_edge_columns();
        // Far map corner, rays pointing negative.
        write_camera(4194303, 4194303, -131072, -131072, 131072, 131072);
        queue_edge_columns();
        // Exactly on grid lines, rays along x only, then both components zero.
        write_camera(65536 * 5, 65536 * 63, 131072, 0, 0, 0);
        queue_edge_columns();
        write_camera(100, 70000, 0, 0, 0, 0);
        column_queue.push_back(COL_W'(3));
        column_queue.push_back('1);
        // A write to an unused index must leave the registers alone.
        wait_drained();
        write_reg(REG_UNUSED, 4194303);
        column_queue.push_back(COL_W'(9));

        // Random part under three idle patterns.
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct  = (phase == 0) ? 17 : (phase == 1) ? 52 : 0;
            recv_stall_pct = (phase == 0) ? 52 : (phase == 1) ? 17 : 0;
            repeat (3) begin
                random_camera();
                queue_random_columns(120);
                if (phase == 2) hold_request = 1'b1;
            end
            // A further stretch of random columns under the phase's idle pattern.
            queue_random_columns(24);
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
